[design/acfb_pkg.sv]
// acfb_pkg: shared types, frame layout constants and helper functions
// for the air-conditioner ir frame builder
// no dependencies
package acfb_pkg;

  localparam int FRAME_LEN = 21;
  localparam int SEC_LEN   = 7;
  localparam int SEC_COUNT = 3;

  typedef logic [7:0]                  byte_t;
  typedef logic [FRAME_LEN-1:0][7:0]   frame_t;
  typedef logic [4:0]                  idx_t;
  typedef logic [1:0]                  sec_t;
  typedef logic [2:0]                  pos_t;
  typedef logic [3:0]                  cnt8_t;
  typedef logic [5:0]                  cnt_t;

  localparam idx_t LAST_IDX = idx_t'(FRAME_LEN - 1);
  localparam pos_t LAST_POS = pos_t'(SEC_LEN - 1);
  localparam sec_t LAST_SEC = sec_t'(SEC_COUNT - 1);

  // command byte positions inside the frame
  localparam int POS_QUIET    = 5;
  localparam int POS_PWR_A    = 6;
  localparam int POS_SWING    = 16;
  localparam int POS_TEMP     = 18;
  localparam int POS_MODE_FAN = 19;
  localparam int POS_PWR_B    = 20;

  localparam byte_t PWR_ON_BYTE  = 8'hF0;
  localparam byte_t PWR_OFF_BYTE = 8'hC0;
  localparam byte_t CHK_BASE     = 8'hFF;

  // one accepted command
  typedef struct packed {
    byte_t temp_code;
    byte_t mode_code;
    byte_t fan_code;
    byte_t quiet_code;
    byte_t swing_code;
    logic  power_on;
  } cmd_t;

  // fixed frame template, before command fields and checksums
  function automatic byte_t tmpl_byte(input idx_t idx);
    byte_t b;
    case (idx)
      5'd0:    b = 8'h02;
      5'd1:    b = 8'h02;
      5'd2:    b = 8'h0F;
      5'd6:    b = 8'hF0;
      5'd7:    b = 8'h01;
      5'd8:    b = 8'hD2;
      5'd9:    b = 8'h0F;
      5'd14:   b = 8'h01;
      5'd15:   b = 8'h02;
      5'd17:   b = 8'h71;
      5'd20:   b = 8'hF0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // count of one bits in a byte
  function automatic cnt8_t ones8(input byte_t v);
    cnt8_t n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + cnt8_t'(v[i]);
    end
    return n;
  endfunction

endpackage

[design/ac_ir_frame_builder.sv]
// ac_ir_frame_builder: air-conditioner ir frame builder, 21 bytes per command
// a command passes the input register, the serializer frame register and the
// registered byte ports, then its 21 bytes strobe on consecutive cycles from
// the one-byte-per-cycle frame serializer; a second command may wait in the
// input register, so frames follow with no gap; the receiver cannot stall.
// reset (rst_n low, synchronous) drops any held command and frame in progress
module ac_ir_frame_builder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_temp_code,
  input  logic [7:0] in_mode_code,
  input  logic [7:0] in_fan_code,
  input  logic [7:0] in_quiet_code,
  input  logic [7:0] in_swing_code,
  input  logic       in_power_on,
  output logic       out_strobe,
  output logic [7:0] out_frame_byte,
  output logic [1:0] out_section_index,
  output logic       out_section_first,
  output logic       out_frame_last
);

  acfb_pkg::cmd_t   cmd_r, cmd_nxt;
  logic             pend_r, pend_nxt;
  logic             accept;
  logic             load;
  logic             load_ok;
  acfb_pkg::frame_t frame;

  // input register: one command held until the serializer takes it
  assign load   = pend_r && load_ok;
  assign busy   = pend_r && !load_ok;
  assign accept = start && !busy;

  always_comb begin
    pend_nxt = accept || (pend_r && !load);
    cmd_nxt  = cmd_r;
    if (accept) begin
      cmd_nxt.temp_code  = in_temp_code;
      cmd_nxt.mode_code  = in_mode_code;
      cmd_nxt.fan_code   = in_fan_code;
      cmd_nxt.quiet_code = in_quiet_code;
      cmd_nxt.swing_code = in_swing_code;
      cmd_nxt.power_on   = in_power_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // frame assembly and checksums
  acfb_frame_calc u_calc (
    .cmd   (cmd_r),
    .frame (frame)
  );

  // byte output
  acfb_serializer u_ser (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .frame_in          (frame),
    .load_ok           (load_ok),
    .out_strobe        (out_strobe),
    .out_frame_byte    (out_frame_byte),
    .out_section_index (out_section_index),
    .out_section_first (out_section_first),
    .out_frame_last    (out_frame_last)
  );

  // last byte belongs to the final section
  a_last_sec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_frame_last |-> out_section_index == acfb_pkg::LAST_SEC)
    else $error("frame end outside last section");

  // no gap inside a frame
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_frame_last |=> out_strobe && !out_section_first
      || out_strobe && out_section_first && out_section_index != '0)
    else $error("gap or restart inside a frame");

  // an accepted command is held for the serializer
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_r)
    else $error("accepted command lost");

  // busy only when a command is waiting
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> pend_r && !load)
    else $error("busy without a waiting command");

endmodule

[design/acfb_frame_calc.sv]
// acfb_frame_calc: builds the 21-byte frame with per-section checksums
// from one registered command, purely combinational
// depends on acfb_pkg
module acfb_frame_calc (
  input  acfb_pkg::cmd_t   cmd,
  output acfb_pkg::frame_t frame
);

  always_comb begin
    acfb_pkg::frame_t f;
    acfb_pkg::cnt_t   cnt;
    acfb_pkg::byte_t  chk;
    acfb_pkg::byte_t  pwr;

    // template
    for (int k = 0; k < acfb_pkg::FRAME_LEN; k++) begin
      f[k] = acfb_pkg::tmpl_byte(acfb_pkg::idx_t'(k));
    end

    // command fields
    pwr = cmd.power_on ? acfb_pkg::PWR_ON_BYTE : acfb_pkg::PWR_OFF_BYTE;
    f[acfb_pkg::POS_PWR_A]    = pwr;
    f[acfb_pkg::POS_PWR_B]    = pwr;
    f[acfb_pkg::POS_QUIET]    = cmd.quiet_code;
    f[acfb_pkg::POS_SWING]    = cmd.swing_code;
    f[acfb_pkg::POS_TEMP]     = cmd.temp_code;
    f[acfb_pkg::POS_MODE_FAN] = cmd.mode_code | cmd.fan_code;

    // per-section checksum: 255 minus the one-bit count, split in nibbles
    for (int s = 0; s < acfb_pkg::SEC_COUNT; s++) begin
      cnt = acfb_pkg::cnt_t'(acfb_pkg::ones8(f[s*acfb_pkg::SEC_LEN]))
          + acfb_pkg::cnt_t'(acfb_pkg::ones8({4'h0, f[s*acfb_pkg::SEC_LEN+1][3:0]}))
          + acfb_pkg::cnt_t'(acfb_pkg::ones8({f[s*acfb_pkg::SEC_LEN+2][7:4], 4'h0}))
          + acfb_pkg::cnt_t'(acfb_pkg::ones8(f[s*acfb_pkg::SEC_LEN+3]))
          + acfb_pkg::cnt_t'(acfb_pkg::ones8(f[s*acfb_pkg::SEC_LEN+4]))
          + acfb_pkg::cnt_t'(acfb_pkg::ones8(f[s*acfb_pkg::SEC_LEN+5]))
          + acfb_pkg::cnt_t'(acfb_pkg::ones8(f[s*acfb_pkg::SEC_LEN+6]));
      chk = acfb_pkg::CHK_BASE - {2'b00, cnt};
      f[s*acfb_pkg::SEC_LEN+1][7:4] = f[s*acfb_pkg::SEC_LEN+1][7:4] | chk[3:0];
      f[s*acfb_pkg::SEC_LEN+2][3:0] = f[s*acfb_pkg::SEC_LEN+2][3:0] | chk[7:4];
    end

    frame = f;
  end

endmodule

[design/acfb_serializer.sv]
// acfb_serializer: holds one finished frame and sends it out one byte
// per cycle through registered result ports, with section markers
// depends on acfb_pkg
module acfb_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  acfb_pkg::frame_t frame_in,
  output logic             load_ok,
  output logic             out_strobe,
  output logic [7:0]       out_frame_byte,
  output logic [1:0]       out_section_index,
  output logic             out_section_first,
  output logic             out_frame_last
);

  acfb_pkg::frame_t frame_r, frame_nxt;
  logic             active_r, active_nxt;
  acfb_pkg::idx_t   idx_r, idx_nxt;
  acfb_pkg::sec_t   sec_r, sec_nxt;
  acfb_pkg::pos_t   pos_r, pos_nxt;
  logic             strobe_r, strobe_nxt;
  acfb_pkg::byte_t  byte_r, byte_nxt;
  acfb_pkg::sec_t   osec_r, osec_nxt;
  logic             ofirst_r, ofirst_nxt;
  logic             olast_r, olast_nxt;
  logic             last_byte;

  assign last_byte = (idx_r == acfb_pkg::LAST_IDX);
  // a new frame may enter while the last byte of the current one goes out
  assign load_ok   = !active_r || last_byte;

  // send one byte per cycle, load a new frame when idle or at the end of a frame
  always_comb begin
    frame_nxt  = frame_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    sec_nxt    = sec_r;
    pos_nxt    = pos_r;
    strobe_nxt = 1'b0;
    byte_nxt   = byte_r;
    osec_nxt   = osec_r;
    ofirst_nxt = ofirst_r;
    olast_nxt  = olast_r;

    if (active_r) begin
      strobe_nxt = 1'b1;
      byte_nxt   = frame_r[idx_r];
      osec_nxt   = sec_r;
      ofirst_nxt = (pos_r == '0);
      olast_nxt  = last_byte;
      idx_nxt    = idx_r + 5'd1;
      if (pos_r == acfb_pkg::LAST_POS) begin
        pos_nxt = '0;
        sec_nxt = sec_r + 2'd1;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
      if (last_byte) begin
        active_nxt = 1'b0;
      end
    end

    if (load) begin
      frame_nxt  = frame_in;
      active_nxt = 1'b1;
      idx_nxt    = '0;
      sec_nxt    = '0;
      pos_nxt    = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      sec_r    <= '0;
      pos_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      sec_r    <= sec_nxt;
      pos_r    <= pos_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    frame_r  <= frame_nxt;
    byte_r   <= byte_nxt;
    osec_r   <= osec_nxt;
    ofirst_r <= ofirst_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_frame_byte    = byte_r;
  assign out_section_index = osec_r;
  assign out_section_first = ofirst_r;
  assign out_frame_last    = olast_r;

  // a byte is sent in every cycle of an active frame
  a_active_sends: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |=> strobe_r)
    else $error("active frame produced no byte");

  // counters stay in step
  a_counters: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && last_byte |-> (sec_r == acfb_pkg::LAST_SEC) && (pos_r == acfb_pkg::LAST_POS))
    else $error("section counters out of step with byte index");

endmodule
